// ===== sv/sphere_from_four_points_core_assert.svh =====
// Assertion macros shared by the sphere solver RTL.
`ifndef SPHERE_FROM_FOUR_POINTS_CORE_ASSERT_SVH
`define SPHERE_FROM_FOUR_POINTS_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SFFP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SFFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sffp_pkg.sv =====
// Shared constants, width functions and types of the sphere solver.
package sffp_pkg;

    localparam int COORD_BITS_DEF = 13;
    localparam int FRAC_BITS_DEF  = 4;
    localparam int OUT_W          = 32;
    // Center quotients are clipped at the output width.
    localparam int CQ_BITS        = OUT_W;
    // Radius root needs one bit more than the output to see a rounding carry.
    localparam int RS_BITS        = OUT_W + 1;
    localparam int RQ_BITS        = 2 * RS_BITS;
    // The radius operands leave the front end this many stages after the center ones.
    localparam int FRONT_GAP      = 2;

    localparam logic [OUT_W-1:0] S_MIN = {1'b1, {(OUT_W-1){1'b0}}};
    localparam logic [OUT_W-1:0] S_MAX = {1'b0, {(OUT_W-1){1'b1}}};

    function automatic int w_t(input int cb, input int fb);
        return 4 * cb + 8 + fb;
    endfunction

    function automatic int w_dd(input int cb);
        return 3 * cb + 5;
    endfunction

    function automatic int w_s2(input int cb, input int fb);
        return 2 * (4 * cb + 5) + 2 + 2 * fb;
    endfunction

    function automatic int w_d2(input int cb);
        return 2 * (3 * cb + 3);
    endfunction

    typedef struct packed {
        logic [2:0]                neg;
        logic [2:0]                ovf;
        logic [2:0][CQ_BITS-1:0]   q;
    } t_cres;

    typedef struct packed {
        logic signed [OUT_W-1:0] center_x;
        logic signed [OUT_W-1:0] center_y;
        logic signed [OUT_W-1:0] center_z;
        logic [OUT_W-1:0]        radius;
        logic                    not_sphere;
        logic                    saturated;
    } t_res;

endpackage

// ===== sv/sffp_if.sv =====
// Stream interfaces for the point input and the sphere result.
interface sffp_in_if #(
    parameter int COORD_BITS = sffp_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] p0_x, p0_y, p0_z;
    logic signed [COORD_BITS-1:0] p1_x, p1_y, p1_z;
    logic signed [COORD_BITS-1:0] p2_x, p2_y, p2_z;
    logic signed [COORD_BITS-1:0] p3_x, p3_y, p3_z;

    modport source (
        output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
        output p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
        input  ready
    );
    modport sink (
        input  valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
        input  p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
        output ready
    );
endinterface

interface sffp_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [sffp_pkg::OUT_W-1:0] center_x, center_y, center_z;
    logic [sffp_pkg::OUT_W-1:0]        radius;
    logic                              not_sphere;
    logic                              saturated;

    modport source (
        output valid, center_x, center_y, center_z, radius, not_sphere, saturated,
        input  ready
    );
    modport sink (
        input  valid, center_x, center_y, center_z, radius, not_sphere, saturated,
        output ready
    );
endinterface

// ===== sv/sffp_front.sv =====
// Front end: differences, cross products, determinant, numerators and squares.
module sffp_front #(
    parameter int COORD_BITS = sffp_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sffp_pkg::FRAC_BITS_DEF,
    localparam int TW  = sffp_pkg::w_t(COORD_BITS, FRAC_BITS),
    localparam int DDW = sffp_pkg::w_dd(COORD_BITS),
    localparam int S2W = sffp_pkg::w_s2(COORD_BITS, FRAC_BITS),
    localparam int D2W = sffp_pkg::w_d2(COORD_BITS)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  logic signed [COORD_BITS-1:0] i_p [4][3],
    output logic                         o_cvld,
    output logic [TW-1:0]                o_t [3],
    output logic [DDW-1:0]               o_dd,
    output logic [2:0]                   o_cneg,
    output logic                         o_rvld,
    output logic                         o_zero,
    output logic [S2W-1:0]               o_s2,
    output logic [D2W-1:0]               o_d2
);

    localparam int CB   = COORD_BITS;
    localparam int DW   = CB + 1;
    localparam int BW   = 2 * CB + 3;
    localparam int CRW  = 2 * CB + 2;
    localparam int DTW  = 3 * CB + 4;
    localparam int DMW  = 3 * CB + 3;
    localparam int TPW  = BW + CRW;
    localparam int NW   = 4 * CB + 6;
    localparam int DPW  = DTW + CB + 1;
    localparam int NUMW = NW + 1;
    localparam int NMW  = 4 * CB + 5;
    localparam int MAGW = 4 * CB + 6;
    localparam int H    = (NMW + 1) / 2;
    localparam int HL   = NMW - H;
    localparam int HD   = (DMW + 1) / 2;
    localparam int HDL  = DMW - HD;
    localparam int SQW  = 2 * NMW;
    localparam int NHHW = 2 * HL;
    localparam int NHLW = HL + H;
    localparam int NLLW = 2 * H;
    localparam int DHHW = 2 * HDL;
    localparam int DHLW = HDL + HD;
    localparam int DLLW = 2 * HD;

    logic [8:1] r_vld;

    logic signed [CB-1:0]   r1_p0 [3];
    logic signed [DW-1:0]   r1_d [3][3];
    logic signed [CB-1:0]   r2_p0 [3];
    logic signed [DW-1:0]   r2_d0 [3];
    logic signed [BW-1:0]   r2_b [3];
    logic signed [CRW-1:0]  r2_cr [3][3];
    logic signed [CB-1:0]   r3_p0 [3];
    logic signed [DTW-1:0]  r3_det;
    logic signed [TPW-1:0]  r3_t [3][3];
    logic signed [NW-1:0]   r4_n [3];
    logic signed [DPW-1:0]  r4_dp [3];
    logic signed [DTW-1:0]  r4_det;
    logic signed [NUMW-1:0] r5_num [3];
    logic [NMW-1:0]         r5_absn [3];
    logic [DMW-1:0]         r5_absd;
    logic                   r5_dneg, r5_zero;
    logic [TW-1:0]          r6_t [3];
    logic [DDW-1:0]         r6_dd;
    logic [2:0]             r6_cneg;
    logic                   r6_zero;
    logic [NHHW-1:0]        r6_nhh [3];
    logic [NHLW-1:0]        r6_nhl [3];
    logic [NLLW-1:0]        r6_nll [3];
    logic [DHHW-1:0]        r6_dhh;
    logic [DHLW-1:0]        r6_dhl;
    logic [DLLW-1:0]        r6_dll;
    logic [SQW-1:0]         r7_sq [3];
    logic [D2W-1:0]         r7_d2;
    logic                   r7_zero;
    logic [S2W-1:0]         r8_s2;
    logic [D2W-1:0]         r8_d2;
    logic                   r8_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[7:1], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Stage 1: offsets from the first point.
            for (int k = 0; k < 3; k++) begin
                r1_p0[k] <= i_p[0][k];
                for (int i = 0; i < 3; i++) begin
                    r1_d[i][k] <= DW'(i_p[i+1][k]) - DW'(i_p[0][k]);
                end
            end
            // Stage 2: squared lengths and cross products.
            for (int i = 0; i < 3; i++) begin
                int ia, ic;
                ia = (i == 2) ? 0 : i + 1;
                ic = (i == 0) ? 2 : i - 1;
                r2_p0[i] <= r1_p0[i];
                r2_d0[i] <= r1_d[0][i];
                r2_b[i]  <= BW'(r1_d[i][0]) * BW'(r1_d[i][0])
                          + BW'(r1_d[i][1]) * BW'(r1_d[i][1])
                          + BW'(r1_d[i][2]) * BW'(r1_d[i][2]);
                r2_cr[i][0] <= CRW'(r1_d[ia][1]) * CRW'(r1_d[ic][2])
                             - CRW'(r1_d[ia][2]) * CRW'(r1_d[ic][1]);
                r2_cr[i][1] <= CRW'(r1_d[ia][2]) * CRW'(r1_d[ic][0])
                             - CRW'(r1_d[ia][0]) * CRW'(r1_d[ic][2]);
                r2_cr[i][2] <= CRW'(r1_d[ia][0]) * CRW'(r1_d[ic][1])
                             - CRW'(r1_d[ia][1]) * CRW'(r1_d[ic][0]);
            end
            // Stage 3: determinant and the nine weighted cross terms.
            r3_det <= DTW'(r2_d0[0]) * DTW'(r2_cr[0][0])
                    + DTW'(r2_d0[1]) * DTW'(r2_cr[0][1])
                    + DTW'(r2_d0[2]) * DTW'(r2_cr[0][2]);
            for (int i = 0; i < 3; i++) begin
                r3_p0[i] <= r2_p0[i];
                for (int k = 0; k < 3; k++) begin
                    r3_t[i][k] <= TPW'(r2_b[i]) * TPW'(r2_cr[i][k]);
                end
            end
            // Stage 4: offset center numerators and the 2*D*p0 terms.
            r4_det <= r3_det;
            for (int k = 0; k < 3; k++) begin
                r4_n[k]  <= NW'(r3_t[0][k]) + NW'(r3_t[1][k]) + NW'(r3_t[2][k]);
                r4_dp[k] <= (DPW'(r3_det) * DPW'(r3_p0[k])) <<< 1;
            end
            // Stage 5: full numerators and magnitudes.
            r5_dneg <= r4_det[DTW-1];
            r5_zero <= (r4_det == '0);
            r5_absd <= r4_det[DTW-1] ? DMW'(-r4_det) : DMW'(r4_det);
            for (int k = 0; k < 3; k++) begin
                r5_num[k]  <= NUMW'(r4_n[k]) + NUMW'(r4_dp[k]);
                r5_absn[k] <= r4_n[k][NW-1] ? NMW'(-r4_n[k]) : NMW'(r4_n[k]);
            end
            // Stage 6: rounding dividends and split squares.
            r6_zero <= r5_zero;
            r6_dd   <= DDW'(r5_absd) << 2;
            for (int k = 0; k < 3; k++) begin
                logic [MAGW-1:0] mag;
                logic [HL-1:0]   hi;
                logic [H-1:0]    lo;
                mag = r5_num[k][NUMW-1] ? MAGW'(-r5_num[k]) : MAGW'(r5_num[k]);
                hi  = r5_absn[k][NMW-1:H];
                lo  = r5_absn[k][H-1:0];
                // Round to nearest: (2|num| + |den|) / (2|den|) with den = 2D.
                r6_t[k]    <= (TW'(mag) << (FRAC_BITS + 1)) + (TW'(r5_absd) << 1);
                r6_cneg[k] <= r5_num[k][NUMW-1] ^ r5_dneg;
                r6_nhh[k]  <= NHHW'(hi) * NHHW'(hi);
                r6_nhl[k]  <= NHLW'(hi) * NHLW'(lo);
                r6_nll[k]  <= NLLW'(lo) * NLLW'(lo);
            end
            r6_dhh <= DHHW'(r5_absd[DMW-1:HD]) * DHHW'(r5_absd[DMW-1:HD]);
            r6_dhl <= DHLW'(r5_absd[DMW-1:HD]) * DHLW'(r5_absd[HD-1:0]);
            r6_dll <= DLLW'(r5_absd[HD-1:0]) * DLLW'(r5_absd[HD-1:0]);
            // Stage 7: combine partial products.
            r7_zero <= r6_zero;
            for (int k = 0; k < 3; k++) begin
                r7_sq[k] <= (SQW'(r6_nhh[k]) << (2 * H)) + (SQW'(r6_nhl[k]) << (H + 1))
                          + SQW'(r6_nll[k]);
            end
            r7_d2 <= (D2W'(r6_dhh) << (2 * HD)) + (D2W'(r6_dhl) << (HD + 1)) + D2W'(r6_dll);
            // Stage 8: scaled sum of squares.
            r8_zero <= r7_zero;
            r8_d2   <= r7_d2;
            r8_s2   <= (S2W'(r7_sq[0]) + S2W'(r7_sq[1]) + S2W'(r7_sq[2])) << (2 * FRAC_BITS);
        end
    end

    assign o_cvld = r_vld[6];
    assign o_t    = r6_t;
    assign o_dd   = r6_dd;
    assign o_cneg = r6_cneg;
    assign o_rvld = r_vld[8];
    assign o_zero = r8_zero;
    assign o_s2   = r8_s2;
    assign o_d2   = r8_d2;

endmodule

// ===== sv/sffp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with an overflow flag.
module sffp_div #(
    parameter int NUM_W  = 64,
    parameter int DEN_W  = 32,
    parameter int Q_BITS = sffp_pkg::CQ_BITS,
    parameter int SB_W   = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SB_W-1:0]   i_sb,
    output logic              o_vld,
    output logic [Q_BITS-1:0] o_q,
    output logic              o_ovf,
    output logic [SB_W-1:0]   o_sb
);

    localparam int RW = (NUM_W > DEN_W + Q_BITS) ? NUM_W : DEN_W + Q_BITS;

    logic              r_vld [Q_BITS];
    logic [RW-1:0]     r_rem [Q_BITS];
    logic [Q_BITS-1:0] r_q   [Q_BITS];
    logic [DEN_W-1:0]  r_den [Q_BITS];
    logic [SB_W-1:0]   r_sb  [Q_BITS];
    logic              r_ovf [Q_BITS];

    for (genvar j = 0; j < Q_BITS; j++) begin : g_stg
        logic [RW-1:0]     w_rem_in, w_sh;
        logic [Q_BITS-1:0] w_q_in;
        logic [DEN_W-1:0]  w_den;
        logic [SB_W-1:0]   w_sb;
        logic              w_ovf, w_vld, w_ge;

        if (j == 0) begin : g_first
            assign w_rem_in = RW'(i_num);
            assign w_q_in   = '0;
            assign w_den    = i_den;
            assign w_sb     = i_sb;
            assign w_vld    = i_vld;
            // A quotient that does not fit in Q_BITS is flagged here.
            assign w_ovf    = RW'(i_num) >= (RW'(i_den) << Q_BITS);
        end else begin : g_next
            assign w_rem_in = r_rem[j-1];
            assign w_q_in   = r_q[j-1];
            assign w_den    = r_den[j-1];
            assign w_sb     = r_sb[j-1];
            assign w_vld    = r_vld[j-1];
            assign w_ovf    = r_ovf[j-1];
        end

        assign w_sh = RW'(w_den) << (Q_BITS - 1 - j);
        assign w_ge = w_rem_in >= w_sh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= w_ge ? w_rem_in - w_sh : w_rem_in;
                r_q[j]   <= w_q_in | (Q_BITS'(w_ge) << (Q_BITS - 1 - j));
                r_den[j] <= w_den;
                r_sb[j]  <= w_sb;
                r_ovf[j] <= w_ovf;
            end
        end
    end

    assign o_vld = r_vld[Q_BITS-1];
    assign o_q   = r_q[Q_BITS-1];
    assign o_ovf = r_ovf[Q_BITS-1];
    assign o_sb  = r_sb[Q_BITS-1];

endmodule

// ===== sv/sffp_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module sffp_sqrt #(
    parameter int X_W  = sffp_pkg::RQ_BITS,
    parameter int SB_W = 2,
    localparam int S   = (X_W + 1) / 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  logic [X_W-1:0]  i_x,
    input  logic [SB_W-1:0] i_sb,
    output logic            o_vld,
    output logic [S-1:0]    o_root,
    output logic [SB_W-1:0] o_sb
);

    localparam int XR = X_W + 1;

    logic            r_vld [S];
    logic [XR-1:0]   r_x   [S];
    logic [XR-1:0]   r_res [S];
    logic [SB_W-1:0] r_sb  [S];

    for (genvar j = 0; j < S; j++) begin : g_stg
        logic [XR-1:0]   w_x_in, w_res_in, w_bit, w_t;
        logic [SB_W-1:0] w_sb;
        logic            w_vld, w_ge;

        if (j == 0) begin : g_first
            assign w_x_in   = XR'(i_x);
            assign w_res_in = '0;
            assign w_sb     = i_sb;
            assign w_vld    = i_vld;
        end else begin : g_next
            assign w_x_in   = r_x[j-1];
            assign w_res_in = r_res[j-1];
            assign w_sb     = r_sb[j-1];
            assign w_vld    = r_vld[j-1];
        end

        assign w_bit = XR'(1) << (2 * (S - 1 - j));
        assign w_t   = w_res_in + w_bit;
        assign w_ge  = w_x_in >= w_t;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[j]   <= w_ge ? w_x_in - w_t : w_x_in;
                r_res[j] <= w_ge ? (w_res_in >> 1) + w_bit : w_res_in >> 1;
                r_sb[j]  <= w_sb;
            end
        end
    end

    assign o_vld  = r_vld[S-1];
    assign o_root = r_res[S-1][S-1:0];
    assign o_sb   = r_sb[S-1];

endmodule

// ===== sv/sphere_from_four_points_core.sv =====
// Sphere through four points: one transaction per clock, fully pipelined (8 front-end
// stages, a 66-stage radius divider, a 33-stage square root and the output register);
// the center dividers run 32 stages and wait in a matching delay line.
// The whole pipeline advances together and holds while a result waits at the output, so
// the sustained rate is one item per cycle whenever the sink takes results. Coplanar
// points give not_sphere with all other fields zero; clipped values set saturated.
`include "sphere_from_four_points_core_assert.svh"

module sphere_from_four_points_core #(
    parameter int COORD_BITS = sffp_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sffp_pkg::FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sffp_in_if.sink    i_pts,
    sffp_out_if.source o_sph
);

    localparam int TW    = sffp_pkg::w_t(COORD_BITS, FRAC_BITS);
    localparam int DDW   = sffp_pkg::w_dd(COORD_BITS);
    localparam int S2W   = sffp_pkg::w_s2(COORD_BITS, FRAC_BITS);
    localparam int D2W   = sffp_pkg::w_d2(COORD_BITS);
    localparam int OUT_W = sffp_pkg::OUT_W;
    localparam int RS    = sffp_pkg::RS_BITS;
    localparam int DLY   = sffp_pkg::FRONT_GAP + sffp_pkg::RQ_BITS + RS
                         - sffp_pkg::CQ_BITS;

    logic                         w_en;
    logic signed [COORD_BITS-1:0] w_p [4][3];

    logic                 w_fcvld, w_frvld, w_fzero;
    logic [TW-1:0]        w_ft [3];
    logic [DDW-1:0]       w_fdd;
    logic [2:0]           w_fcneg;
    logic [S2W-1:0]       w_fs2;
    logic [D2W-1:0]       w_fd2;

    logic [2:0]                    w_cvld, w_covf, w_cneg;
    logic [sffp_pkg::CQ_BITS-1:0]  w_cq [3];

    logic                          w_rvld, w_rovf, w_rzero;
    logic [sffp_pkg::RQ_BITS-1:0]  w_rq;

    logic            w_svld;
    logic [RS-1:0]   w_root;
    logic [1:0]      w_ssb;

    sffp_pkg::t_cres r_cdly  [DLY];
    logic            r_cdvld [DLY];
    sffp_pkg::t_cres w_cres;

    logic            r_ovld;
    sffp_pkg::t_res  r_res;
    sffp_pkg::t_res  n_res;

    assign w_en        = !r_ovld || o_sph.ready;
    assign i_pts.ready = w_en;

    assign w_p[0] = '{i_pts.p0_x, i_pts.p0_y, i_pts.p0_z};
    assign w_p[1] = '{i_pts.p1_x, i_pts.p1_y, i_pts.p1_z};
    assign w_p[2] = '{i_pts.p2_x, i_pts.p2_y, i_pts.p2_z};
    assign w_p[3] = '{i_pts.p3_x, i_pts.p3_y, i_pts.p3_z};

    sffp_front #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_pts.valid),
        .i_p     (w_p),
        .o_cvld  (w_fcvld),
        .o_t     (w_ft),
        .o_dd    (w_fdd),
        .o_cneg  (w_fcneg),
        .o_rvld  (w_frvld),
        .o_zero  (w_fzero),
        .o_s2    (w_fs2),
        .o_d2    (w_fd2)
    );

    for (genvar k = 0; k < 3; k++) begin : g_cdiv
        sffp_div #(
            .NUM_W  (TW),
            .DEN_W  (DDW),
            .Q_BITS (sffp_pkg::CQ_BITS),
            .SB_W   (1)
        ) u_cdiv (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_fcvld),
            .i_num   (w_ft[k]),
            .i_den   (w_fdd),
            .i_sb    (w_fcneg[k]),
            .o_vld   (w_cvld[k]),
            .o_q     (w_cq[k]),
            .o_ovf   (w_covf[k]),
            .o_sb    (w_cneg[k])
        );
    end

    sffp_div #(
        .NUM_W  (S2W),
        .DEN_W  (D2W),
        .Q_BITS (sffp_pkg::RQ_BITS),
        .SB_W   (1)
    ) u_rdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_frvld),
        .i_num   (w_fs2),
        .i_den   (w_fd2),
        .i_sb    (w_fzero),
        .o_vld   (w_rvld),
        .o_q     (w_rq),
        .o_ovf   (w_rovf),
        .o_sb    (w_rzero)
    );

    sffp_sqrt #(
        .X_W  (sffp_pkg::RQ_BITS),
        .SB_W (2)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_rvld),
        .i_x     (w_rq),
        .i_sb    ({w_rzero, w_rovf}),
        .o_vld   (w_svld),
        .o_root  (w_root),
        .o_sb    (w_ssb)
    );

    // Center quotients wait here until the radius root is done.
    assign w_cres.neg = w_cneg;
    assign w_cres.ovf = w_covf;
    assign w_cres.q   = {w_cq[2], w_cq[1], w_cq[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DLY; s++) begin
                r_cdvld[s] <= 1'b0;
            end
        end else if (w_en) begin
            r_cdvld[0] <= w_cvld[0];
            for (int s = 1; s < DLY; s++) begin
                r_cdvld[s] <= r_cdvld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cdly[0] <= w_cres;
            for (int s = 1; s < DLY; s++) begin
                r_cdly[s] <= r_cdly[s-1];
            end
        end
    end

    always_comb begin
        sffp_pkg::t_cres        c;
        logic [2:0][OUT_W-1:0]  cval;
        logic [2:0]             csat;
        logic [RS:0]            rinc;
        logic                   rsat;
        logic [OUT_W-1:0]       lim;
        c = r_cdly[DLY-1];
        for (int k = 0; k < 3; k++) begin
            lim     = c.neg[k] ? sffp_pkg::S_MIN : sffp_pkg::S_MAX;
            csat[k] = c.ovf[k] || (c.q[k] > lim);
            if (csat[k]) begin
                cval[k] = lim;
            end else begin
                cval[k] = c.neg[k] ? OUT_W'(-c.q[k]) : c.q[k];
            end
        end
        // A root of all ones rounds up past the output range.
        rsat = w_ssb[0] || (&w_root);
        rinc = {1'b0, w_root} + (RS + 1)'(1);
        if (w_ssb[1]) begin
            n_res = '0;
            n_res.not_sphere = 1'b1;
        end else begin
            n_res.center_x   = cval[0];
            n_res.center_y   = cval[1];
            n_res.center_z   = cval[2];
            n_res.radius     = rsat ? '1 : rinc[OUT_W:1];
            n_res.not_sphere = 1'b0;
            n_res.saturated  = (|csat) || rsat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_ovld <= w_svld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_res <= n_res;
        end
    end

    assign o_sph.valid      = r_ovld;
    assign o_sph.center_x   = r_res.center_x;
    assign o_sph.center_y   = r_res.center_y;
    assign o_sph.center_z   = r_res.center_z;
    assign o_sph.radius     = r_res.radius;
    assign o_sph.not_sphere = r_res.not_sphere;
    assign o_sph.saturated  = r_res.saturated;

    `SFFP_ASSERT_NOW(a_cdiv_lockstep, i_clk, i_rst_n, 1'b1, (w_cvld[0] == w_cvld[1]) && (w_cvld[1] == w_cvld[2]), "center dividers out of lockstep")
    `SFFP_ASSERT_NOW(a_path_align, i_clk, i_rst_n, 1'b1, r_cdvld[DLY-1] == w_svld, "center and radius paths out of step")
    `SFFP_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, !w_en, $stable(w_svld) && $stable(r_cdvld[DLY-1]), "pipeline moved during a stall")
    `SFFP_ASSERT_NOW(a_plane_clear, i_clk, i_rst_n, r_ovld && r_res.not_sphere, (r_res.radius == '0) && !r_res.saturated && (r_res.center_x == '0), "coplanar result carries data")

endmodule
